FILE: sv/gid_pkg.sv
// Package for the globals image decompressor.
// Holds parse and sequencer states, result codes, token masks, template tables
// and the structs passed between the sequencer, the offset unit and the top level.
package gid_pkg;

    typedef enum logic [2:0] {
        PH_HEADER   = 3'd0,
        PH_OFFSET   = 3'd1,
        PH_TOKEN    = 3'd2,
        PH_LITERAL  = 3'd3,
        PH_REPVAL   = 3'd4,
        PH_TEMPLATE = 3'd5,
        PH_DONE     = 3'd6,
        PH_HALT     = 3'd7
    } phase_t;

    typedef enum logic [1:0] {
        ST_IN    = 2'd0,
        ST_RUN   = 2'd1,
        ST_TMPL  = 2'd2,
        ST_EVENT = 2'd3
    } seq_state_t;

    localparam logic [1:0] KIND_WRITE   = 2'd0;
    localparam logic [1:0] KIND_SECTION = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;

    localparam logic [1:0] LAST_SECTION = 2'd2;
    localparam logic [7:0] HEADER_BYTES = 8'd4;
    localparam logic [7:0] OFFSET_BYTES = 8'd4;
    localparam logic [3:0] TMPL_LEN     = 4'd8;

    localparam logic [7:0] TOK_END      = 8'h00;
    localparam logic [7:0] LIT_MASK     = 8'h80;
    localparam logic [7:0] LIT_LEN      = 8'h7F;
    localparam logic [7:0] ZERO_MASK    = 8'hC0;
    localparam logic [7:0] ZERO_CODE    = 8'h40;
    localparam logic [7:0] ZERO_LEN     = 8'h3F;
    localparam logic [7:0] REP_MASK     = 8'hE0;
    localparam logic [7:0] REP_CODE     = 8'h20;
    localparam logic [7:0] REP_LEN      = 8'h1F;
    localparam logic [7:0] FF_MASK      = 8'hF0;
    localparam logic [7:0] FF_CODE      = 8'h10;
    localparam logic [7:0] FF_LEN       = 8'h0F;
    localparam logic [7:0] TMPL_FIRST   = 8'h01;
    localparam logic [7:0] TMPL_LAST    = 8'h04;
    localparam logic [7:0] BYTE_ONES    = 8'hFF;
    localparam logic [7:0] BYTE_LDA     = 8'hA9;
    localparam logic [7:0] BYTE_F0      = 8'hF0;

    typedef struct packed {
        logic        clear;
        logic        step;
    } pos_cmd_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] write_offset;
        logic [7:0]  write_value;
        logic [1:0]  section_number;
        logic        last_of_run;
    } result_t;

    // bit i set: template byte i comes from the input
    function automatic logic [7:0] tmpl_embed(input logic [1:0] id);
        logic [7:0] m;
        case (id)
            2'd0:    m = 8'hC0;
            2'd1:    m = 8'hE0;
            2'd2:    m = 8'hB0;
            default: m = 8'hB8;
        endcase
        return m;
    endfunction

    function automatic logic [7:0] tmpl_byte(input logic [1:0] id, input logic [2:0] idx);
        logic [7:0] v;
        v = 8'h00;
        if (id[1] == 1'b0)
        begin
            if (idx == 3'd4 || (idx == 3'd5 && id[0] == 1'b0))
            begin
                v = BYTE_ONES;
            end
        end
        else
        begin
            if (idx == 3'd0)
            begin
                v = BYTE_LDA;
            end
            else if (idx == 3'd1)
            begin
                v = BYTE_F0;
            end
        end
        return v;
    endfunction

    function automatic logic tmpl_fixed_at(input logic [1:0] id, input logic [3:0] idx);
        logic [7:0] m;
        m = tmpl_embed(id);
        return (idx < TMPL_LEN) && !m[idx[2:0]];
    endfunction

endpackage

FILE: sv/gid_offset_unit.sv
// Offset unit of the globals image decompressor: position counter and the
// shared adder that forms data_size + section offset + position. Uses gid_pkg.
module gid_offset_unit
    import gid_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  pos_cmd_t    cmd,
    input  logic [31:0] data_size,
    input  logic [31:0] sec_offset,
    output logic [31:0] offset
);

    logic [31:0] pos_reg;
    logic [31:0] pos_next;

    always_comb
    begin
        pos_next = pos_reg;
        if (cmd.clear)
        begin
            pos_next = '0;
        end
        else if (cmd.step)
        begin
            pos_next = pos_reg + 32'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    assign offset = data_size + sec_offset + pos_reg;

endmodule

FILE: sv/gid_sequencer.sv
// Parser and result sequencer of the globals image decompressor.
// Decodes header, offsets and tokens, then walks runs and templates one
// result per cycle through gid_offset_unit while res_ready is high. Uses gid_pkg.
module gid_sequencer
    import gid_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        in_restart,
    input  logic [31:0] data_size,
    output logic        res_valid,
    input  logic        res_ready,
    output result_t     res
);

    seq_state_t  state_reg, state_next;
    phase_t      phase_reg, phase_next;
    logic [7:0]  cnt_reg, cnt_next;
    logic [31:0] sec_off_reg, sec_off_next;
    logic [1:0]  section_reg, section_next;
    logic [6:0]  run_cnt_reg, run_cnt_next;
    logic [7:0]  run_val_reg, run_val_next;
    logic        follow_reg, follow_next;
    logic [1:0]  tmpl_id_reg, tmpl_id_next;
    logic [3:0]  tmpl_idx_reg, tmpl_idx_next;
    logic [1:0]  evt_kind_reg, evt_kind_next;
    logic [7:0]  evt_val_reg, evt_val_next;

    logic        clear_pos;
    logic        accept;
    logic        emit_take;
    logic [3:0]  idx_inc;
    logic [31:0] offset;
    pos_cmd_t    pos_cmd;

    phase_t      eff_phase;
    logic [7:0]  eff_cnt;
    logic [1:0]  eff_section;

    assign accept    = in_valid && in_ready;
    assign emit_take = res_valid && res_ready;
    assign idx_inc   = tmpl_idx_reg + 4'd1;

    gid_offset_unit u_offset (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (pos_cmd),
        .data_size  (data_size),
        .sec_offset (sec_off_reg),
        .offset     (offset)
    );

    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        cnt_next      = cnt_reg;
        sec_off_next  = sec_off_reg;
        section_next  = section_reg;
        run_cnt_next  = run_cnt_reg;
        run_val_next  = run_val_reg;
        follow_next   = follow_reg;
        tmpl_id_next  = tmpl_id_reg;
        tmpl_idx_next = tmpl_idx_reg;
        evt_kind_next = evt_kind_reg;
        evt_val_next  = evt_val_reg;
        clear_pos     = 1'b0;
        eff_phase     = in_restart ? PH_HEADER : phase_reg;
        eff_cnt       = in_restart ? 8'd0 : cnt_reg;
        eff_section   = in_restart ? 2'd0 : section_reg;

        case (state_reg)
            ST_IN:
            begin
                if (accept)
                begin
                    section_next = eff_section;
                    clear_pos    = in_restart;
                    if (in_restart)
                    begin
                        sec_off_next = '0;
                    end
                    case (eff_phase)
                        PH_HEADER:
                        begin
                            cnt_next   = eff_cnt + 8'd1;
                            phase_next = PH_HEADER;
                            if (eff_cnt + 8'd1 >= HEADER_BYTES)
                            begin
                                phase_next   = PH_OFFSET;
                                cnt_next     = '0;
                                sec_off_next = '0;
                                clear_pos    = 1'b1;
                            end
                        end
                        PH_OFFSET:
                        begin
                            sec_off_next = {sec_off_reg[23:0], in_byte};
                            cnt_next     = eff_cnt + 8'd1;
                            if (eff_cnt + 8'd1 >= OFFSET_BYTES)
                            begin
                                phase_next = PH_TOKEN;
                                cnt_next   = '0;
                                clear_pos  = 1'b1;
                            end
                        end
                        PH_TOKEN:
                        begin
                            if (in_byte == TOK_END)
                            begin
                                state_next    = ST_EVENT;
                                evt_kind_next = KIND_SECTION;
                                evt_val_next  = '0;
                                phase_next    = (section_reg >= LAST_SECTION) ? PH_DONE
                                                                              : PH_OFFSET;
                                cnt_next      = '0;
                            end
                            else if ((in_byte & LIT_MASK) == LIT_MASK)
                            begin
                                cnt_next   = (in_byte & LIT_LEN) + 8'd1;
                                phase_next = PH_LITERAL;
                            end
                            else if ((in_byte & ZERO_MASK) == ZERO_CODE)
                            begin
                                state_next   = ST_RUN;
                                run_cnt_next = 7'((in_byte & ZERO_LEN) + 8'd1);
                                run_val_next = 8'h00;
                                follow_next  = 1'b0;
                            end
                            else if ((in_byte & REP_MASK) == REP_CODE)
                            begin
                                cnt_next   = (in_byte & REP_LEN) + 8'd2;
                                phase_next = PH_REPVAL;
                            end
                            else if ((in_byte & FF_MASK) == FF_CODE)
                            begin
                                state_next   = ST_RUN;
                                run_cnt_next = 7'((in_byte & FF_LEN) + 8'd1);
                                run_val_next = BYTE_ONES;
                                follow_next  = 1'b0;
                            end
                            else if (in_byte >= TMPL_FIRST && in_byte <= TMPL_LAST)
                            begin
                                state_next    = ST_TMPL;
                                tmpl_id_next  = 2'(in_byte - TMPL_FIRST);
                                tmpl_idx_next = '0;
                                phase_next    = PH_TEMPLATE;
                            end
                            else
                            begin
                                state_next    = ST_EVENT;
                                evt_kind_next = KIND_ERROR;
                                evt_val_next  = in_byte;
                                phase_next    = PH_HALT;
                            end
                        end
                        PH_LITERAL:
                        begin
                            state_next   = ST_RUN;
                            run_cnt_next = 7'd1;
                            run_val_next = in_byte;
                            follow_next  = 1'b0;
                            cnt_next     = eff_cnt - 8'd1;
                            if (eff_cnt == 8'd1)
                            begin
                                phase_next = PH_TOKEN;
                            end
                        end
                        PH_REPVAL:
                        begin
                            state_next   = ST_RUN;
                            run_cnt_next = 7'(eff_cnt);
                            run_val_next = in_byte;
                            follow_next  = 1'b0;
                            phase_next   = PH_TOKEN;
                        end
                        PH_TEMPLATE:
                        begin
                            state_next    = ST_RUN;
                            run_cnt_next  = 7'd1;
                            run_val_next  = in_byte;
                            tmpl_idx_next = idx_inc;
                            follow_next   = tmpl_fixed_at(tmpl_id_reg, idx_inc);
                            if (idx_inc == TMPL_LEN)
                            begin
                                phase_next = PH_TOKEN;
                            end
                        end
                        default:
                        begin
                            phase_next = eff_phase;
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                if (emit_take)
                begin
                    run_cnt_next = run_cnt_reg - 7'd1;
                    if (run_cnt_reg == 7'd1)
                    begin
                        state_next = follow_reg ? ST_TMPL : ST_IN;
                    end
                end
            end
            ST_TMPL:
            begin
                if (emit_take)
                begin
                    tmpl_idx_next = idx_inc;
                    if (!tmpl_fixed_at(tmpl_id_reg, idx_inc))
                    begin
                        state_next = ST_IN;
                        phase_next = (idx_inc == TMPL_LEN) ? PH_TOKEN : PH_TEMPLATE;
                    end
                end
            end
            ST_EVENT:
            begin
                if (emit_take)
                begin
                    state_next = ST_IN;
                    if (evt_kind_reg == KIND_SECTION && section_reg < LAST_SECTION)
                    begin
                        section_next = section_reg + 2'd1;
                        sec_off_next = '0;
                        clear_pos    = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IN;
            end
        endcase
    end

    always_comb
    begin
        in_ready           = 1'b0;
        res_valid          = 1'b0;
        res.kind           = KIND_WRITE;
        res.write_offset   = offset;
        res.write_value    = run_val_reg;
        res.section_number = section_reg;
        res.last_of_run    = 1'b0;
        case (state_reg)
            ST_IN:
            begin
                in_ready = 1'b1;
            end
            ST_RUN:
            begin
                res_valid       = 1'b1;
                res.last_of_run = (run_cnt_reg == 7'd1) &&
                                  !(follow_reg && tmpl_fixed_at(tmpl_id_reg, tmpl_idx_reg));
            end
            ST_TMPL:
            begin
                res_valid       = 1'b1;
                res.write_value = tmpl_byte(tmpl_id_reg, tmpl_idx_reg[2:0]);
                res.last_of_run = !tmpl_fixed_at(tmpl_id_reg, idx_inc);
            end
            ST_EVENT:
            begin
                res_valid        = 1'b1;
                res.kind         = evt_kind_reg;
                res.write_offset = '0;
                res.write_value  = evt_val_reg;
                res.last_of_run  = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
        pos_cmd.clear = clear_pos;
        pos_cmd.step  = emit_take && (state_reg == ST_RUN || state_reg == ST_TMPL);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IN;
            phase_reg    <= PH_HEADER;
            cnt_reg      <= '0;
            sec_off_reg  <= '0;
            section_reg  <= '0;
            run_cnt_reg  <= '0;
            run_val_reg  <= '0;
            follow_reg   <= 1'b0;
            tmpl_id_reg  <= '0;
            tmpl_idx_reg <= '0;
            evt_kind_reg <= KIND_WRITE;
            evt_val_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            cnt_reg      <= cnt_next;
            sec_off_reg  <= sec_off_next;
            section_reg  <= section_next;
            run_cnt_reg  <= run_cnt_next;
            run_val_reg  <= run_val_next;
            follow_reg   <= follow_next;
            tmpl_id_reg  <= tmpl_id_next;
            tmpl_idx_reg <= tmpl_idx_next;
            evt_kind_reg <= evt_kind_next;
            evt_val_reg  <= evt_val_next;
        end
    end

    a_run_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RUN |-> run_cnt_reg != 7'd0)
        else $error("run state with empty count");

    a_tmpl_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_TMPL |-> tmpl_fixed_at(tmpl_id_reg, tmpl_idx_reg))
        else $error("template walk on a non-fixed byte");

    a_error_halts: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_take && res.kind == KIND_ERROR) |=> phase_reg == PH_HALT)
        else $error("error result without halt");

    a_section_range: assert property (@(posedge clk) disable iff (!rst_n)
        section_reg <= LAST_SECTION)
        else $error("section number out of range");

    a_last_leaves: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_take && res.last_of_run) |=> state_reg == ST_IN)
        else $error("last result did not return to input");

endmodule

FILE: sv/globals_image_decompressor_unit.sv
// Top level of the globals image decompressor: configuration register,
// gid_sequencer and the registered result stage. Uses gid_pkg.
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tdata: resource_byte; tuser: restart
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata: write_offset, write_value,
//                                              section_number; tuser: kind; tlast
//  data_size in   data_size_wr_en              data_size_wr_data
//
// Each input item is accepted and then causes 0 to 64 results, which the shared offset
// adder forms at one result per cycle while the result register can take them.
// Input is not ready while results of the previous item are being produced.
// The result register holds an item while m_axis_tready is low and stalls the walk.
// Asynchronous active-low reset clears the parser and sets data_size to 0.
module globals_image_decompressor_unit
    import gid_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] resource_byte
    input  logic        s_axis_tuser,   // [0] restart
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [31:0] write_offset, [39:32] write_value,
                                        // [41:40] section_number, [47:42] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast,
    input  logic        data_size_wr_en,
    input  logic [31:0] data_size_wr_data
);

    logic [31:0] data_size_reg, data_size_next;
    logic        out_valid_reg, out_valid_next;
    result_t     out_reg, out_next;
    logic        res_valid;
    logic        res_ready;
    result_t     res;

    gid_sequencer u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_byte    (s_axis_tdata),
        .in_restart (s_axis_tuser),
        .data_size  (data_size_reg),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        data_size_next = data_size_wr_en ? data_size_wr_data : data_size_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_ready)
        begin
            out_valid_next = res_valid;
            out_next       = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_size_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            data_size_reg <= data_size_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_reg.section_number, out_reg.write_value,
                            out_reg.write_offset};
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tlast  = out_reg.last_of_run;

endmodule
